FILE: hw/rtl/sha256_stream_hasher_defines.svh
// Assertion macros used by the hash core of the stream hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// Checks that a condition implies a consequence in the same cycle.
`define SHS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define SHS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared constants, types and functions of the stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    typedef logic [31:0] word_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        begin
            case (i)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic word_t init_vector(input logic [2:0] i);
        word_t h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/shs_item_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short first-in first-out queue between the input front and the hash core.
// ----------------------------------------------------------------------------
module shs_item_queue
    import shs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t            slot_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg, rptr_reg;
    logic [QAW:0]     count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != QDEPTH[QAW:0]);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
        end
    end

endmodule

FILE: hw/rtl/shs_core.sv
// ----------------------------------------------------------------------------
// Hash core
// Buffers bytes, pads, runs one SHA-256 round per cycle and emits the digest.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"
module shs_core
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FEED  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t       state_reg;
    word_t        h_reg [8];
    word_t        v_reg [8];
    word_t        w_reg [16];
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [5:0]   rnd_reg;
    logic [5:0]   pad_reg;
    logic         fin_reg;
    logic         second_reg;
    logic         pend_reg;
    logic [2:0]   oidx_reg;
    logic [2:0]   onum_reg;
    logic [31:0]  ow_reg;
    logic         ovalid_reg;

    word_t        s0, s1, wnew, wcur, t1, t2, e, a;
    word_t        lenw;
    logic [7:0]   pbyte;
    logic         out_free;
    logic         load_out;

    assign out_free  = !ovalid_reg || out_ready;
    assign load_out  = (state_reg == S_OUT) && out_free;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign digest_word = ow_reg;
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    always_comb
    begin
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        wcur = w_reg[0];
        e    = v_reg[4];
        a    = v_reg[0];
        t1   = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(rnd_reg) + wcur;
        t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        lenw = pad_reg[2] ? len_reg[31:0] : len_reg[63:32];
        if (pad_reg == fill_reg && !second_reg)
        begin
            pbyte = 8'h80;
        end
        else
        begin
            pbyte = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            rnd_reg    <= '0;
            pad_reg    <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            pend_reg   <= 1'b0;
            oidx_reg   <= '0;
            onum_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_vector(3'(i));
            end
        end
        else
        begin
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fin_reg    <= in_item.end_of_message;
                        second_reg <= 1'b0;
                        pend_reg   <= in_item.has_byte && fill_reg == 6'd63
                                      && in_item.end_of_message;
                        pad_reg    <= fill_reg + {5'd0, in_item.has_byte};
                        if (in_item.has_byte)
                        begin
                            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8]
                                <= in_item.data_byte;
                            fill_reg <= fill_reg + 1'b1;
                            len_reg  <= len_reg + 64'd8;
                        end
                        if (in_item.has_byte && fill_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                            rnd_reg   <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                        else if (in_item.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // Fills one byte per cycle from pad_reg to the end of the block.
                    if (pad_reg >= 6'd56 && (fill_reg < 6'd56 || second_reg))
                    begin
                        w_reg[pad_reg[5:2]][8*(3-pad_reg[1:0]) +: 8]
                            <= lenw[8*(3-pad_reg[1:0]) +: 8];
                    end
                    else
                    begin
                        w_reg[pad_reg[5:2]][8*(3-pad_reg[1:0]) +: 8] <= pbyte;
                    end
                    pad_reg <= pad_reg + 1'b1;
                    if (pad_reg == 6'd63)
                    begin
                        state_reg <= S_ROUND;
                        rnd_reg   <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                    end
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= e;
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= a;
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_FEED;
                    end
                end
                S_FEED:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    fill_reg <= '0;
                    if (!fin_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (pend_reg)
                    begin
                        pend_reg   <= 1'b0;
                        second_reg <= 1'b0;
                        pad_reg    <= '0;
                        state_reg  <= S_PAD;
                    end
                    else if (!second_reg && fill_reg >= 6'd56)
                    begin
                        second_reg <= 1'b1;
                        pad_reg    <= '0;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        onum_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        ow_reg   <= h_reg[onum_reg];
                        oidx_reg <= onum_reg;
                        onum_reg <= onum_reg + 1'b1;
                        if (onum_reg == 3'd7)
                        begin
                            state_reg <= S_IDLE;
                            len_reg   <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_vector(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SHS_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE,
        "core takes a transaction outside idle")
    `SHS_ASSERT_NEXT(a_round_end, clk, rst_n,
        state_reg == S_ROUND && rnd_reg == 6'd63, state_reg == S_FEED,
        "round count out of step")
    `SHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(digest_word) && $stable(word_index),
        "digest word changed while stalled")

endmodule

FILE: hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with SHA-256 and delivers the digest word by word.
// ----------------------------------------------------------------------------
// The input channel takes one transaction per byte; has_byte marks a real
// byte and end_of_message closes the message. A four-entry queue decouples
// the input from the hash core, so the sender can run ahead briefly.
// The core takes a byte only while idle; the 64th byte of a block starts the
// rounds and then the feed-forward, and the core takes no input meanwhile.
// At end of message the core pads one byte per cycle, compresses one or two
// blocks, then presents eight digest words, one per cycle while the receiver
// is ready, word 0 first, last_word on word 7.
// While the output is stalled the core holds the current word and waits;
// the queue keeps taking input until it is full.
// Reset loads the initial hash vector and empties the queue.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item = '{data_byte: data_byte, has_byte: has_byte,
                       end_of_message: end_of_message};

    shs_item_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_item  (in_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    shs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

FILE: dv/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Sends directed and random byte messages, predicts each digest word by word,
// and compares every output transaction against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    import shs_pkg::*;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } digest_entry_t;

    localparam bit [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    class digest_board;
        bit [31:0]     hash_state [8];
        bit [7:0]      block_bytes [64];
        int            fill;
        bit [63:0]     bit_count;
        digest_entry_t pending_words [$];
        int            errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] = IV_TABLE[i];
            end
            fill = 0;
            bit_count = '0;
        endfunction

        function bit [31:0] ror(bit [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress();
            bit [31:0] w [64];
            bit [31:0] v [8];
            bit [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            end
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = hash_state;
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] += v[i];
            end
        endfunction

        function void note_item(bit [7:0] data, bit valid_byte, bit closes);
            int pos;
            digest_entry_t e;
            if (valid_byte)
            begin
                block_bytes[fill] = data;
                fill++;
                bit_count += 64'd8;
                if (fill == 64)
                begin
                    compress();
                    fill = 0;
                end
            end
            if (!closes)
                return;
            pos = fill;
            block_bytes[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
            begin
                block_bytes[63 - i] = bit_count[8*i +: 8];
            end
            compress();
            for (int i = 0; i < 8; i++)
            begin
                e.word = hash_state[i];
                e.index = i[2:0];
                e.last = (i == 7);
                pending_words.push_back(e);
            end
            restart();
        endfunction

        function void check_word(bit [31:0] word, bit [2:0] index, bit last);
            digest_entry_t e;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, word);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (word !== e.word)
            begin
                $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
                errors++;
            end
            if (index !== e.index)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time, e.index, index);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last_word expected %0d actual %0d", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    bit          clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_board board = new();
    int  items_sent = 0;
    bit  quiet = 1'b0;
    bit  long_hold = 1'b0;

    sha256_stream_hasher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(digest_word, word_index, last_word);
    end

    initial
    begin
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(bit [7:0] data, bit valid_byte, bit closes);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        has_byte <= valid_byte;
        end_of_message <= closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(data, valid_byte, closes);
        items_sent++;
    endtask

    task automatic send_message(int len, bit separate_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1,
                      (i == len - 1) && !separate_end);
        end
        if (len == 0 || separate_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (board.pending_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #5ms;
        $display("sha256_stream_hasher: mismatch");
        $finish;
    end

    initial
    begin
        int len;
        int pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, then two bytes each carrying the end, then a lone byte after an
        // empty transaction and followed by an end-only transaction, then a three-byte message.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // Stall the output while several messages pile up behind it.
        long_hold = 1'b1;
        send_message(3, 1'b0);
        send_message(40, 1'b1);
        send_message(0, 1'b0);

        while (items_sent < 330)
        begin
            if (items_sent > 280)
                quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(53, 66);
            else
                len = $urandom_range(110, 130);
            if (len > 330 - items_sent)
                len = 330 - items_sent;
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("sha256_stream_hasher: match");
        else
            $display("sha256_stream_hasher: mismatch");
        $finish;
    end

endmodule
